@@ design/tild_pkg.sv @@
// tild_pkg: item layouts, codes and character constants of the tty input line discipline
// no dependencies; imported by the interface users, controller and datapath
package tild_pkg;

    // input item
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  key_code;
        logic        is_extended;
        logic [1:0]  ext_kind;
        logic [15:0] request_count;
    } req_item_t;

    // result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] position;
        logic        last;
    } rsp_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic arm;
        logic key_exec;
        logic drain_read;
        logic drain_exec;
        logic push_step;
        logic finish_step;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       ring_empty;
        logic       list_empty;
        logic       held_valid;
        logic       out_free;
    } ctrl_stat_t;

    // function codes
    localparam logic [1:0] FUNC_KEY   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_DRAIN = 2'd2;

    // extended key kinds
    localparam logic [1:0] EXT_OTHER = 2'd0;
    localparam logic [1:0] EXT_ENTER = 2'd1;
    localparam logic [1:0] EXT_BS    = 2'd2;
    localparam logic [1:0] EXT_TAB   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ECHO    = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_RETRACT = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_STRIP_HIGH_BIT    = 3'd0;
    localparam logic [2:0] CFG_EXTENSIONS_ENABLE = 3'd1;
    localparam logic [2:0] CFG_LITERAL_NEXT_CHAR = 3'd2;
    localparam logic [2:0] CFG_IGNORE_CR         = 3'd3;
    localparam logic [2:0] CFG_MAP_CR_TO_NL      = 3'd4;
    localparam logic [2:0] CFG_MAP_NL_TO_CR      = 3'd5;
    localparam logic [2:0] CFG_ECHO_ENABLE       = 3'd6;

    localparam logic [7:0] LITERAL_NEXT_RESET = 8'd22;

    // characters
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] LOW7_MASK = 8'h7F;

endpackage

@@ design/tild_stream_if.sv @@
// tild_stream_if: valid/ready channel carrying one item of a given payload type
// depends on nothing; payload types come from tild_pkg at the point of use
interface tild_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/tild_ctrl.sv @@
// tild_ctrl: sequencing state machine of the tty input line discipline
// depends on tild_pkg (command and status structs, function codes)
module tild_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tild_pkg::ctrl_stat_t  stat,
    output tild_pkg::ctrl_cmd_t   cmd
);
    import tild_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_KEY_EXEC,
        ST_DRAIN_READ,
        ST_DRAIN_EXEC,
        ST_PUSH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   drain_reg;

    // commands decoded from state and status
    always_comb
    begin
        cmd             = '0;
        cmd.load_item   = (state_reg == ST_IDLE) && req_valid;
        cmd.arm         = (state_reg == ST_DISPATCH) && (stat.func == FUNC_READ);
        cmd.key_exec    = (state_reg == ST_KEY_EXEC);
        cmd.drain_read  = (state_reg == ST_DRAIN_READ) && !stat.ring_empty;
        cmd.drain_exec  = (state_reg == ST_DRAIN_EXEC);
        cmd.push_step   = (state_reg == ST_PUSH) && !stat.list_empty
                          && (!stat.held_valid || stat.out_free);
        cmd.finish_step = (state_reg == ST_FINISH) && stat.held_valid && stat.out_free;
    end

    assign req_ready = (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                        state_reg <= ST_DISPATCH;
                end
                ST_DISPATCH:
                begin
                    drain_reg <= (stat.func == FUNC_DRAIN);
                    unique case (stat.func)
                        FUNC_KEY:   state_reg <= ST_KEY_EXEC;
                        FUNC_DRAIN: state_reg <= ST_DRAIN_READ;
                        default:    state_reg <= ST_IDLE;
                    endcase
                end
                ST_KEY_EXEC:
                    state_reg <= ST_PUSH;
                ST_DRAIN_READ:
                begin
                    if (stat.ring_empty)
                        state_reg <= ST_FINISH;
                    else
                        state_reg <= ST_DRAIN_EXEC;
                end
                ST_DRAIN_EXEC:
                    state_reg <= ST_PUSH;
                ST_PUSH:
                begin
                    if (stat.list_empty)
                        state_reg <= drain_reg ? ST_DRAIN_READ : ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!stat.held_valid || stat.out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ design/tild_datapath.sv @@
// tild_datapath: configuration, key conditioning, key ring, read counters and result staging
// depends on tild_pkg; driven by tild_ctrl through command and status structs
module tild_datapath #(
    parameter int RING_DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  tild_pkg::req_item_t   req_data,
    input  tild_pkg::ctrl_cmd_t   cmd,
    output tild_pkg::ctrl_stat_t  stat,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output tild_pkg::rsp_item_t   rsp_data
);
    import tild_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    // configuration registers
    logic       strip_high_bit_reg;
    logic       extensions_enable_reg;
    logic [7:0] literal_next_char_reg;
    logic       ignore_cr_reg;
    logic       map_cr_to_nl_reg;
    logic       map_nl_to_cr_reg;
    logic       echo_enable_reg;

    // item and ring state
    req_item_t        item_reg;
    logic [7:0]       ring_mem [RING_DEPTH];
    logic [7:0]       ring_rdata_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic             escape_reg;
    logic [15:0]      remaining_reg;
    logic [15:0]      delivered_reg;

    // result staging: up to two fresh results, one held result, output register
    rsp_item_t  slot0_reg;
    rsp_item_t  slot1_reg;
    logic [1:0] list_cnt_reg;
    rsp_item_t  held_reg;
    logic       held_valid_reg;
    rsp_item_t  out_reg;
    logic       out_valid_reg;

    logic ring_full;
    logic out_free;
    assign ring_full = (count_reg == CNT_W'(RING_DEPTH));
    assign out_free  = !out_valid_reg || rsp_ready;

    // key conditioning
    logic [7:0] key8;
    logic       key_ext;
    logic       key_push;
    logic [7:0] push_byte;
    logic       escape_next;
    logic [1:0] echo_cnt;
    logic [7:0] echo0;
    logic [7:0] echo1;

    always_comb
    begin
        key8        = strip_high_bit_reg ? (item_reg.key_code & LOW7_MASK) : item_reg.key_code;
        key_ext     = strip_high_bit_reg ? 1'b0 : item_reg.is_extended;
        key_push    = 1'b0;
        push_byte   = key8;
        escape_next = escape_reg;
        echo_cnt    = 2'd0;
        echo0       = key8;
        echo1       = CH_V;
        priority if (extensions_enable_reg && escape_reg)
        begin
            escape_next = 1'b0;
            key_push    = 1'b1;
            echo_cnt    = 2'd1;
        end
        else if (extensions_enable_reg && !key_ext && key8 == literal_next_char_reg)
        begin
            escape_next = 1'b1;
            echo0       = CH_CARET;
            echo_cnt    = 2'd2;
        end
        else if (!key_ext)
        begin
            if (key8 == CH_CR)
            begin
                if (!ignore_cr_reg)
                begin
                    push_byte = map_cr_to_nl_reg ? CH_LF : CH_CR;
                    key_push  = 1'b1;
                    echo_cnt  = 2'd1;
                end
            end
            else
            begin
                if (key8 == CH_LF && map_nl_to_cr_reg)
                    push_byte = CH_CR;
                key_push = 1'b1;
                echo_cnt = 2'd1;
            end
            echo0 = push_byte;
        end
        else
        begin
            unique case (item_reg.ext_kind)
                EXT_ENTER:
                begin
                    push_byte = CH_LF;
                    key_push  = 1'b1;
                    echo_cnt  = 2'd1;
                end
                EXT_BS:
                begin
                    push_byte = CH_BS;
                    key_push  = 1'b1;
                    echo_cnt  = (delivered_reg != 16'd0) ? 2'd1 : 2'd0;
                end
                EXT_TAB:
                begin
                    push_byte = CH_TAB;
                    key_push  = 1'b1;
                    echo_cnt  = 2'd1;
                end
                default:
                begin
                    key_push = 1'b0;
                end
            endcase
            echo0 = push_byte;
        end
        if (!echo_enable_reg)
            echo_cnt = 2'd0;
    end

    // echo result items
    rsp_item_t echo_r0;
    rsp_item_t echo_r1;

    always_comb
    begin
        echo_r0           = '0;
        echo_r0.kind      = KIND_ECHO;
        echo_r0.data_byte = echo0;
        echo_r1           = '0;
        echo_r1.kind      = KIND_ECHO;
        echo_r1.data_byte = echo1;
    end

    // drain step on the byte read from the ring
    logic [15:0] remaining_next;
    logic [15:0] delivered_next;
    rsp_item_t   drain_r0;
    rsp_item_t   drain_r1;
    logic [1:0]  drain_cnt;
    rsp_item_t   done_item;

    always_comb
    begin
        remaining_next = remaining_reg;
        delivered_next = delivered_reg;
        drain_r0       = '0;
        drain_r1       = '0;
        drain_cnt      = 2'd0;
        done_item      = '0;
        if (remaining_reg != 16'd0)
        begin
            if (ring_rdata_reg >= CH_SPACE && ring_rdata_reg <= CH_TILDE)
            begin
                drain_r0.kind      = KIND_DELIVER;
                drain_r0.data_byte = ring_rdata_reg;
                drain_r0.position  = delivered_reg;
                delivered_next     = delivered_reg + 16'd1;
                remaining_next     = remaining_reg - 16'd1;
                drain_cnt          = 2'd1;
            end
            else if (ring_rdata_reg == CH_BS && delivered_reg != 16'd0)
            begin
                delivered_next     = delivered_reg - 16'd1;
                remaining_next     = remaining_reg + 16'd1;
                drain_r0.kind      = KIND_RETRACT;
                drain_r0.data_byte = CH_BS;
                drain_r0.position  = delivered_next;
                drain_cnt          = 2'd1;
            end
            if (ring_rdata_reg == CH_LF || remaining_next == 16'd0)
            begin
                done_item.kind     = KIND_DONE;
                done_item.position = delivered_next;
                remaining_next     = 16'd0;
                if (drain_cnt == 2'd0)
                    drain_r0 = done_item;
                else
                    drain_r1 = done_item;
                drain_cnt = drain_cnt + 2'd1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_high_bit_reg    <= 1'b0;
            extensions_enable_reg <= 1'b1;
            literal_next_char_reg <= LITERAL_NEXT_RESET;
            ignore_cr_reg         <= 1'b0;
            map_cr_to_nl_reg      <= 1'b1;
            map_nl_to_cr_reg      <= 1'b0;
            echo_enable_reg       <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STRIP_HIGH_BIT:    strip_high_bit_reg    <= cfg_data[0];
                CFG_EXTENSIONS_ENABLE: extensions_enable_reg <= cfg_data[0];
                CFG_LITERAL_NEXT_CHAR: literal_next_char_reg <= cfg_data;
                CFG_IGNORE_CR:         ignore_cr_reg         <= cfg_data[0];
                CFG_MAP_CR_TO_NL:      map_cr_to_nl_reg      <= cfg_data[0];
                CFG_MAP_NL_TO_CR:      map_nl_to_cr_reg      <= cfg_data[0];
                CFG_ECHO_ENABLE:       echo_enable_reg       <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.key_exec && key_push && !ring_full)
            ring_mem[head_reg] <= push_byte;
        if (cmd.drain_read)
            ring_rdata_reg <= ring_mem[tail_reg];
    end

    // ring pointers, escape and read counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            escape_reg    <= 1'b0;
            remaining_reg <= '0;
            delivered_reg <= '0;
        end
        else
        begin
            if (cmd.key_exec)
            begin
                escape_reg <= escape_next;
                if (key_push && !ring_full)
                begin
                    head_reg  <= (head_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.drain_read)
            begin
                tail_reg  <= (tail_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.arm)
            begin
                remaining_reg <= item_reg.request_count;
                delivered_reg <= '0;
            end
            if (cmd.drain_exec)
            begin
                remaining_reg <= remaining_next;
                delivered_reg <= delivered_next;
            end
        end
    end

    // staging payloads
    rsp_item_t out_next;
    always_comb
    begin
        out_next      = held_reg;
        out_next.last = cmd.finish_step;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= req_data;
        if (cmd.key_exec)
        begin
            slot0_reg <= echo_r0;
            slot1_reg <= echo_r1;
        end
        else if (cmd.drain_exec)
        begin
            slot0_reg <= drain_r0;
            slot1_reg <= drain_r1;
        end
        else if (cmd.push_step)
            slot0_reg <= slot1_reg;
        if (cmd.push_step)
            held_reg <= slot0_reg;
        if ((cmd.push_step && held_valid_reg) || cmd.finish_step)
            out_reg <= out_next;
    end

    // staging control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_cnt_reg   <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.key_exec)
                list_cnt_reg <= echo_cnt;
            else if (cmd.drain_exec)
                list_cnt_reg <= drain_cnt;
            else if (cmd.push_step)
                list_cnt_reg <= list_cnt_reg - 2'd1;

            if (cmd.push_step)
                held_valid_reg <= 1'b1;
            else if (cmd.finish_step)
                held_valid_reg <= 1'b0;

            if ((cmd.push_step && held_valid_reg) || cmd.finish_step)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // status and output
    assign stat.func       = item_reg.func;
    assign stat.ring_empty = (count_reg == '0);
    assign stat.list_empty = (list_cnt_reg == 2'd0);
    assign stat.held_valid = held_valid_reg;
    assign stat.out_free   = out_free;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

@@ design/tty_input_line_discipline_top.sv @@
// tty_input_line_discipline_top: top level joining controller and datapath
// depends on tild_pkg, tild_stream_if, tild_ctrl and tild_datapath
//
// Terminal input line discipline. One item is worked on at a time. A key item
// (func 0) runs dispatch, key execution, a push per echo result and finish, with
// any wait on the output; a read request (func 1) arms the read counters; a drain
// item (func 2) reads, executes and pushes each ring entry in turn, then finishes,
// paced by the registered read port of the key ring and the single output register.
// Each result waits for the next one or the finish step, so the final result of
// an item is known and marked last. The ring needs no clearing after reset; a key
// that arrives with the ring full is dropped but echoed. The user must write the
// configuration through cfg_we/cfg_index/cfg_data while idle; it is not enforced.
module tty_input_line_discipline_top #(
    parameter int RING_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    tild_stream_if.sink          req,
    tild_stream_if.source        rsp
);
    import tild_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // sequencing
    tild_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // state and result staging
    tild_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req.data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data)
    );

endmodule

@@ dv/tb_tty_input_line_discipline_top.sv @@
// tb_tty_input_line_discipline_top: self-checking bench for the tty input line discipline
// sends key, read and drain items, predicts every result with an untimed model of the
// discipline and compares in order; depends on tild_pkg, tild_stream_if and the top level
module tb_tty_input_line_discipline_top;
    import tild_pkg::*;

    localparam int RING_DEPTH   = 32;
    localparam int STUCK_LIMIT  = 3000;
    localparam int QUIET_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 250;
    localparam int PHASE_ITEMS  = 50;
    localparam int MAX_REPORTS  = 100;

    // function code the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic       strip;
        logic       ext_on;
        logic [7:0] lnext;
        logic       ign_cr;
        logic       cr_to_nl;
        logic       nl_to_cr;
        logic       echo_on;
    } line_cfg_t;

    // one directed row: item plus optional hand-written results
    typedef struct packed {
        req_item_t  item;
        logic       typed;
        logic [1:0] n_res;
        rsp_item_t  res0;
        rsp_item_t  res1;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    tild_stream_if #(.payload_t(req_item_t)) req_ch ();
    tild_stream_if #(.payload_t(rsp_item_t)) rsp_ch ();

    tty_input_line_discipline_top #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // discipline model state
    line_cfg_t   line_cfg;
    logic [7:0]  key_fifo [RING_DEPTH];
    int          fifo_wr;
    int          fifo_rd;
    int          fifo_fill;
    logic        escape_armed;
    logic [15:0] read_left;
    logic [15:0] read_pos;

    rsp_item_t step_results[$];
    rsp_item_t awaited_results[$];
    rsp_item_t typed_results[$];
    logic      typed_active;

    int   mismatches;
    int   stuck_cycles;
    int   random_sent;
    logic no_idle;
    logic hold_req;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic line_cfg_t default_cfg();
        line_cfg_t c;
        c.strip    = 1'b0;
        c.ext_on   = 1'b1;
        c.lnext    = LITERAL_NEXT_RESET;
        c.ign_cr   = 1'b0;
        c.cr_to_nl = 1'b1;
        c.nl_to_cr = 1'b0;
        c.echo_on  = 1'b1;
        return c;
    endfunction

    function automatic void model_reset();
        line_cfg = default_cfg();
        foreach (key_fifo[i])
            key_fifo[i] = 8'h00;
        fifo_wr      = 0;
        fifo_rd      = 0;
        fifo_fill    = 0;
        escape_armed = 1'b0;
        read_left    = '0;
        read_pos     = '0;
    endfunction

    function automatic rsp_item_t out_item(logic [1:0] kind, logic [7:0] data,
                                           logic [15:0] pos, logic last);
        rsp_item_t r;
        r.kind      = kind;
        r.data_byte = data;
        r.position  = pos;
        r.last      = last;
        return r;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [7:0] data, logic [15:0] pos);
        step_results.push_back(out_item(kind, data, pos, 1'b0));
    endfunction

    function automatic void add_echo(logic [7:0] ch);
        if (line_cfg.echo_on)
            add_result(KIND_ECHO, ch, 16'd0);
    endfunction

    // full ring drops the key; the caller still echoes it
    function automatic void fifo_push(logic [7:0] ch);
        if (fifo_fill < RING_DEPTH)
        begin
            key_fifo[fifo_wr] = ch;
            fifo_wr = (fifo_wr + 1) % RING_DEPTH;
            fifo_fill++;
        end
    endfunction

    // key conditioning: strip, escape, cr/lf mapping, extended keys
    function automatic void key_step(req_item_t it);
        logic [7:0] ch;
        logic       ext;
        ch  = it.key_code;
        ext = it.is_extended;
        if (line_cfg.strip)
        begin
            ch  = ch & LOW7_MASK;
            ext = 1'b0;
        end
        if (line_cfg.ext_on && escape_armed)
        begin
            escape_armed = 1'b0;
            fifo_push(ch);
            add_echo(ch);
            return;
        end
        if (line_cfg.ext_on && !ext && ch == line_cfg.lnext)
        begin
            escape_armed = 1'b1;
            add_echo(CH_CARET);
            add_echo(CH_V);
            return;
        end
        if (!ext)
        begin
            if (ch == CH_CR)
            begin
                if (line_cfg.ign_cr)
                    return;
                if (line_cfg.cr_to_nl)
                    ch = CH_LF;
            end
            else if (ch == CH_LF && line_cfg.nl_to_cr)
                ch = CH_CR;
            fifo_push(ch);
            add_echo(ch);
            return;
        end
        case (it.ext_kind)
            EXT_ENTER:
            begin
                fifo_push(CH_LF);
                add_echo(CH_LF);
            end
            EXT_BS:
            begin
                fifo_push(CH_BS);
                if (read_pos != 16'd0)
                    add_echo(CH_BS);
            end
            EXT_TAB:
            begin
                fifo_push(CH_TAB);
                add_echo(CH_TAB);
            end
            default: ;
        endcase
    endfunction

    // empty the ring into the armed read
    function automatic void drain_step();
        logic [7:0] ch;
        while (fifo_fill != 0)
        begin
            ch = key_fifo[fifo_rd];
            fifo_rd = (fifo_rd + 1) % RING_DEPTH;
            fifo_fill--;
            if (read_left == 16'd0)
                continue;
            if (ch >= CH_SPACE && ch <= CH_TILDE)
            begin
                add_result(KIND_DELIVER, ch, read_pos);
                read_pos  = read_pos + 16'd1;
                read_left = read_left - 16'd1;
            end
            else if (ch == CH_BS && read_pos != 16'd0)
            begin
                read_pos  = read_pos - 16'd1;
                read_left = read_left + 16'd1;
                add_result(KIND_RETRACT, CH_BS, read_pos);
            end
            if (ch == CH_LF || read_left == 16'd0)
            begin
                add_result(KIND_DONE, 8'h00, read_pos);
                read_left = '0;
            end
        end
    endfunction

    function automatic void discipline_step(req_item_t it);
        step_results.delete();
        case (it.func)
            FUNC_KEY:   key_step(it);
            FUNC_READ:
            begin
                read_left = it.request_count;
                read_pos  = '0;
            end
            FUNC_DRAIN: drain_step();
            default: ;
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_result(rsp_item_t got);
        rsp_item_t want;
        if (awaited_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result with none expected: kind %0d data %02h pos %0d last %0b",
                         $time, got.kind, got.data_byte, got.position, got.last);
            return;
        end
        want = awaited_results.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: expected %0d %02h %0d %0b, got %0d %02h %0d %0b",
                         $time, want.kind, want.data_byte, want.position, want.last,
                         got.kind, got.data_byte, got.position, got.last);
        end
    endfunction

    // prediction on accepted input, compare on accepted output
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                discipline_step(req_ch.data);
                if (typed_active)
                    foreach (typed_results[i])
                        awaited_results.push_back(typed_results[i]);
                else
                    foreach (step_results[i])
                        awaited_results.push_back(step_results[i]);
            end
            if (rsp_ch.valid && rsp_ch.ready)
                check_result(rsp_ch.data);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no progress, %0d results outstanding", $time, awaited_results.size());
            $display("tty_input_line_discipline_top: mismatch");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int pick;
        if (no_idle)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        int   stall_left;
        logic hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                rsp_ch.ready <= (stall_left == 0);
            end
        end
    end

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_item(req_item_t it);
        int gap;
        req_ch.data  <= it;
        req_ch.valid <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop sending, wait for every result, then let a silent drain finish
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(logic [2:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // single-bit registers get junk in the upper bits
    task automatic load_config(line_cfg_t c);
        put_reg(CFG_STRIP_HIGH_BIT,    {7'($urandom), c.strip});
        put_reg(CFG_EXTENSIONS_ENABLE, {7'($urandom), c.ext_on});
        put_reg(CFG_LITERAL_NEXT_CHAR, c.lnext);
        put_reg(CFG_IGNORE_CR,         {7'($urandom), c.ign_cr});
        put_reg(CFG_MAP_CR_TO_NL,      {7'($urandom), c.cr_to_nl});
        put_reg(CFG_MAP_NL_TO_CR,      {7'($urandom), c.nl_to_cr});
        put_reg(CFG_ECHO_ENABLE,       {7'($urandom), c.echo_on});
        cfg_we <= 1'b0;
        line_cfg = c;
    endtask

    function automatic line_cfg_t random_cfg();
        line_cfg_t c;
        int pick;
        c.strip    = 1'($urandom_range(0, 1));
        c.ext_on   = 1'($urandom_range(0, 1));
        c.ign_cr   = 1'($urandom_range(0, 1));
        c.cr_to_nl = 1'($urandom_range(0, 1));
        c.nl_to_cr = 1'($urandom_range(0, 1));
        c.echo_on  = 1'($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            c.lnext = LITERAL_NEXT_RESET;
        else if (pick < 7)
            c.lnext = CH_CR;
        else
            c.lnext = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic req_item_t noise_item();
        req_item_t it;
        it.func          = 2'($urandom_range(0, 3));
        it.key_code      = 8'($urandom_range(0, 255));
        it.is_extended   = 1'($urandom_range(0, 1));
        it.ext_kind      = 2'($urandom_range(0, 3));
        it.request_count = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic req_item_t key_in(logic [7:0] code, logic ext, logic [1:0] ext_kind);
        req_item_t it;
        it             = '0;
        it.func        = FUNC_KEY;
        it.key_code    = code;
        it.is_extended = ext;
        it.ext_kind    = ext_kind;
        return it;
    endfunction

    function automatic req_item_t read_in(logic [15:0] count);
        req_item_t it;
        it               = '0;
        it.func          = FUNC_READ;
        it.request_count = count;
        return it;
    endfunction

    function automatic req_item_t drain_in();
        req_item_t it;
        it      = '0;
        it.func = FUNC_DRAIN;
        return it;
    endfunction

    function automatic dir_row_t drow(req_item_t it, logic typed, logic [1:0] n,
                                      rsp_item_t r0, rsp_item_t r1);
        dir_row_t row;
        row.item  = it;
        row.typed = typed;
        row.n_res = n;
        row.res0  = r0;
        row.res1  = r1;
        return row;
    endfunction

    // keys biased toward the characters the discipline treats specially
    function automatic req_item_t random_key();
        req_item_t it;
        int pick;
        it = noise_item();
        it.func = FUNC_KEY;
        it.is_extended = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            it.key_code = 8'($urandom_range(CH_SPACE, CH_TILDE));
        else if (pick < 58)
            it.key_code = CH_CR;
        else if (pick < 64)
            it.key_code = CH_LF;
        else if (pick < 70)
            it.key_code = CH_BS;
        else if (pick < 78)
            it.key_code = line_cfg.lnext;
        else if (pick < 88)
            it.is_extended = 1'b1;
        else
            it.is_extended = 1'($urandom_range(0, 1));
        if (line_cfg.strip && pick < 78)
            it.key_code[7] = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [15:0] pick_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 16'($urandom_range(1, 16));
        if (pick < 70)
            return 16'd0;
        if (pick < 85)
            return 16'($urandom_range(17, 40));
        return 16'($urandom_range(0, 65535));
    endfunction

    // mostly read, keys, drain; the rest noise and broken sequences
    task automatic random_session();
        int pick;
        int nkeys;
        req_item_t it;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            it = noise_item();
            it.func = FUNC_UNUSED;
            send_item(it);
            return;
        end
        if (pick < 88)
        begin
            it = noise_item();
            it.func = FUNC_READ;
            it.request_count = pick_count();
            send_item(it);
            random_sent++;
        end
        nkeys = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        repeat (nkeys)
        begin
            send_item(random_key());
            random_sent++;
        end
        if (pick < 95)
        begin
            it = noise_item();
            it.func = FUNC_DRAIN;
            send_item(it);
            random_sent++;
        end
        if ($urandom_range(0, 9) == 0)
            settle();
    endtask

    // main sequence
    initial
    begin
        dir_row_t  dir_table[$];
        rsp_item_t none;
        line_cfg_t c;
        int        phase;
        int        phase_stop;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        typed_active  = 1'b0;
        mismatches    = 0;
        random_sent   = 0;
        none          = '0;
        model_reset();

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows at reset configuration
        dir_table.push_back(drow(key_in(8'h61, 1'b0, EXT_OTHER), 1'b1, 2'd1,
                                 out_item(KIND_ECHO, 8'h61, 16'd0, 1'b1), none));
        // carriage return maps to newline
        dir_table.push_back(drow(key_in(CH_CR, 1'b0, EXT_OTHER), 1'b1, 2'd1,
                                 out_item(KIND_ECHO, CH_LF, 16'd0, 1'b1), none));
        dir_table.push_back(drow(key_in(CH_LF, 1'b0, EXT_OTHER), 1'b1, 2'd1,
                                 out_item(KIND_ECHO, CH_LF, 16'd0, 1'b1), none));
        dir_table.push_back(drow(key_in(8'hFF, 1'b0, EXT_OTHER), 1'b1, 2'd1,
                                 out_item(KIND_ECHO, 8'hFF, 16'd0, 1'b1), none));
        dir_table.push_back(drow(key_in(8'h00, 1'b0, EXT_OTHER), 1'b1, 2'd1,
                                 out_item(KIND_ECHO, 8'h00, 16'd0, 1'b1), none));
        // literal-next echoes caret v, then the next key goes in raw
        dir_table.push_back(drow(key_in(LITERAL_NEXT_RESET, 1'b0, EXT_OTHER), 1'b1, 2'd2,
                                 out_item(KIND_ECHO, CH_CARET, 16'd0, 1'b0),
                                 out_item(KIND_ECHO, CH_V, 16'd0, 1'b1)));
        dir_table.push_back(drow(key_in(CH_CR, 1'b0, EXT_OTHER), 1'b1, 2'd1,
                                 out_item(KIND_ECHO, CH_CR, 16'd0, 1'b1), none));
        // extended keys never match cr or the escape character
        dir_table.push_back(drow(key_in(CH_CR, 1'b1, EXT_ENTER), 1'b1, 2'd1,
                                 out_item(KIND_ECHO, CH_LF, 16'd0, 1'b1), none));
        dir_table.push_back(drow(key_in(8'hFF, 1'b1, EXT_BS), 1'b1, 2'd0, none, none));
        dir_table.push_back(drow(key_in(LITERAL_NEXT_RESET, 1'b1, EXT_TAB), 1'b1, 2'd1,
                                 out_item(KIND_ECHO, CH_TAB, 16'd0, 1'b1), none));
        dir_table.push_back(drow(key_in(8'hFF, 1'b1, EXT_OTHER), 1'b1, 2'd0, none, none));
        // unused function code with every field at its top
        dir_table.push_back(drow('1, 1'b1, 2'd0, none, none));
        // drain with no read armed discards the ring
        dir_table.push_back(drow(drain_in(), 1'b1, 2'd0, none, none));
        dir_table.push_back(drow(read_in(16'hFFFF), 1'b1, 2'd0, none, none));
        dir_table.push_back(drow(key_in(CH_SPACE, 1'b0, EXT_OTHER), 1'b0, 2'd0, none, none));
        dir_table.push_back(drow(key_in(CH_TILDE, 1'b0, EXT_OTHER), 1'b0, 2'd0, none, none));
        dir_table.push_back(drow(key_in(LOW7_MASK, 1'b0, EXT_OTHER), 1'b0, 2'd0, none, none));
        dir_table.push_back(drow(key_in(8'h1F, 1'b0, EXT_OTHER), 1'b0, 2'd0, none, none));
        dir_table.push_back(drow(key_in(8'h6B, 1'b0, EXT_OTHER), 1'b0, 2'd0, none, none));
        dir_table.push_back(drow(key_in(8'h00, 1'b1, EXT_BS), 1'b0, 2'd0, none, none));
        // deliver three, retract one
        dir_table.push_back(drow(drain_in(), 1'b0, 2'd0, none, none));
        // backspace echo now that a byte is delivered
        dir_table.push_back(drow(key_in(8'h00, 1'b1, EXT_BS), 1'b0, 2'd0, none, none));
        // zero count arms nothing
        dir_table.push_back(drow(read_in(16'd0), 1'b1, 2'd0, none, none));
        dir_table.push_back(drow(read_in(16'd1), 1'b0, 2'd0, none, none));
        dir_table.push_back(drow(key_in(8'h71, 1'b0, EXT_OTHER), 1'b0, 2'd0, none, none));
        // count runs out on the single byte
        dir_table.push_back(drow(drain_in(), 1'b1, 2'd2,
                                 out_item(KIND_DELIVER, 8'h71, 16'd0, 1'b0),
                                 out_item(KIND_DONE, 8'h00, 16'd1, 1'b1)));

        foreach (dir_table[i])
        begin
            typed_results.delete();
            if (dir_table[i].n_res > 0)
                typed_results.push_back(dir_table[i].res0);
            if (dir_table[i].n_res > 1)
                typed_results.push_back(dir_table[i].res1);
            typed_active = dir_table[i].typed;
            send_item(dir_table[i].item);
        end
        typed_active = 1'b0;
        settle();

        // receiver holds off while keys overfill the ring, then a full drain
        hold_req = 1'b1;
        repeat (RING_DEPTH + 8)
            send_item(key_in(8'($urandom_range(CH_SPACE, CH_TILDE)), 1'b0, EXT_OTHER));
        send_item(read_in(16'(RING_DEPTH)));
        send_item(drain_in());
        settle();

        // random phases, first three at fixed corner settings
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (phase)
                0: c = '{strip: 1'b1, ext_on: 1'b1, lnext: LOW7_MASK, ign_cr: 1'b1,
                         cr_to_nl: 1'b0, nl_to_cr: 1'b1, echo_on: 1'b1};
                1: c = '{strip: 1'b0, ext_on: 1'b0, lnext: 8'hFF, ign_cr: 1'b0,
                         cr_to_nl: 1'b0, nl_to_cr: 1'b0, echo_on: 1'b0};
                2: c = '{strip: 1'b0, ext_on: 1'b1, lnext: 8'h00, ign_cr: 1'b0,
                         cr_to_nl: 1'b1, nl_to_cr: 1'b1, echo_on: 1'b1};
                default: c = random_cfg();
            endcase
            load_config(c);
            no_idle = (phase % 3 == 2);
            phase_stop = random_sent + PHASE_ITEMS;
            while (random_sent < phase_stop)
                random_session();
            settle();
            phase++;
        end

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("tty_input_line_discipline_top: match");
        else
            $display("tty_input_line_discipline_top: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/tild_pkg.sv
design/tild_stream_if.sv
design/tild_ctrl.sv
design/tild_datapath.sv
design/tty_input_line_discipline_top.sv
dv/tb_tty_input_line_discipline_top.sv
